// ===== rtl/dtrc_pkg.sv =====
`default_nettype none
package dtrc_pkg;

   localparam int unsigned TimeWidth   = 32;
   localparam int unsigned BrightWidth = 8;
   localparam int unsigned CsrWidth    = 16;
   localparam int unsigned CsrIdxWidth = 2;

   // configuration register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_DEBOUNCE_MS     = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_GUARD_MS        = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_FALLBACK_BRIGHT = 2'd2;

   localparam logic [CsrWidth-1:0]    DEBOUNCE_MS_RESET     = 16'd50;
   localparam logic [CsrWidth-1:0]    GUARD_MS_RESET        = 16'd500;
   localparam logic [BrightWidth-1:0] FALLBACK_BRIGHT_RESET = 8'd128;

   // item commands
   localparam logic CMD_POLL = 1'b0;
   localparam logic CMD_SYNC = 1'b1;

   localparam logic LEVEL_PRESSED  = 1'b0;
   localparam logic LEVEL_RELEASED = 1'b1;

   typedef struct packed {
      logic                   cmd;
      logic [TimeWidth-1:0]   now_ms;
      logic                   btn1_level;
      logic                   btn2_level;
      logic [BrightWidth-1:0] bright_now;
      logic [BrightWidth-1:0] bright_last;
      logic                   lit1;
      logic                   lit2;
   } req_type;

   typedef struct packed {
      logic                   ch1_on;
      logic                   ch2_on;
      logic                   master_on;
      logic                   seg1_write;
      logic                   seg2_write;
      logic                   bright_write;
      logic [BrightWidth-1:0] bright_value;
      logic                   sync_taken;
   } rsp_type;

   // control from the top level to one button debouncer
   typedef struct packed {
      logic                 step;
      logic                 level;
      logic [TimeWidth-1:0] now_ms;
   } btn_ctl_type;

endpackage
`default_nettype wire

// ===== rtl/dtrc_req_if.sv =====
`default_nettype none
interface dtrc_req_if;
   import dtrc_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/dtrc_rsp_if.sv =====
`default_nettype none
interface dtrc_rsp_if;
   import dtrc_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/dtrc_debounce.sv =====
`default_nettype none
module dtrc_debounce (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire dtrc_pkg::btn_ctl_type          ctl,
   input  wire logic [dtrc_pkg::CsrWidth-1:0]  debounce_ms,
   output logic                                press
);
   import dtrc_pkg::*;

   logic                 raw_ff, raw_in;
   logic                 stable_ff, stable_in;
   logic [TimeWidth-1:0] when_ff, when_in;
   logic [TimeWidth-1:0] elapsed;
   logic                 settle;

   always_comb begin
      raw_in  = ctl.level;
      when_in = (ctl.level != raw_ff) ? ctl.now_ms : when_ff;
      elapsed = ctl.now_ms - when_in;
      settle  = (elapsed > {{(TimeWidth-CsrWidth){1'b0}}, debounce_ms})
                && (stable_ff != raw_in);
      stable_in = settle ? raw_in : stable_ff;
      press     = ctl.step && settle && (raw_in == LEVEL_PRESSED);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff    <= LEVEL_RELEASED;
         stable_ff <= LEVEL_RELEASED;
         when_ff   <= '0;
      end else if (ctl.step) begin
         raw_ff    <= raw_in;
         stable_ff <= stable_in;
         when_ff   <= when_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/debounced_toggle_relay_controller.sv =====
// Two-channel relay controller with debounced push-button toggles. Each
// request item is either a poll (raw button levels plus a millisecond
// timestamp) or a sync (host lit flags); every item yields exactly one
// response item with the channel and master relay states and any segment or
// brightness write requests. An item is fully processed in the cycle it is
// accepted and its response is registered into an output register, so
// the block sustains one item per clock; the request side stalls only while
// that output register holds a response the sink has not taken. Config
// writes through the csr_ port take effect on the next item.
`default_nettype none
module debounced_toggle_relay_controller (
   input  wire logic                             clock,
   input  wire logic                             reset,
   dtrc_req_if.sink                              req_chan,
   dtrc_rsp_if.source                            rsp_chan,
   input  wire logic                             csr_we,
   input  wire logic [dtrc_pkg::CsrIdxWidth-1:0] csr_index,
   input  wire logic [dtrc_pkg::CsrWidth-1:0]    csr_wdata
);
   import dtrc_pkg::*;

   logic [CsrWidth-1:0]    debounce_ms_ff;
   logic [CsrWidth-1:0]    guard_ms_ff;
   logic [BrightWidth-1:0] fallback_ff;

   logic                   ch1_ff, ch1_in;
   logic                   ch2_ff, ch2_in;
   logic [TimeWidth-1:0]   toggle_time_ff, toggle_time_in;
   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic                   is_poll;
   btn_ctl_type            btn1_ctl, btn2_ctl;
   logic                   press1, press2;
   logic                   ch1_mid;
   logic [BrightWidth-1:0] restore_val;
   logic [BrightWidth-1:0] bright_mid;
   logic                   restore1, restore2;
   logic [TimeWidth-1:0]   since_toggle;
   logic                   sync_ok;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign is_poll        = (req_chan.data.cmd == CMD_POLL);

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ms_ff <= DEBOUNCE_MS_RESET;
         guard_ms_ff    <= GUARD_MS_RESET;
         fallback_ff    <= FALLBACK_BRIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEBOUNCE_MS:     debounce_ms_ff <= csr_wdata;
            CSR_GUARD_MS:        guard_ms_ff    <= csr_wdata;
            CSR_FALLBACK_BRIGHT: fallback_ff    <= csr_wdata[BrightWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      btn1_ctl.step   = accept && is_poll;
      btn1_ctl.level  = req_chan.data.btn1_level;
      btn1_ctl.now_ms = req_chan.data.now_ms;
      btn2_ctl.step   = accept && is_poll;
      btn2_ctl.level  = req_chan.data.btn2_level;
      btn2_ctl.now_ms = req_chan.data.now_ms;
   end

   dtrc_debounce u_btn1 (
      .clock       (clock),
      .reset       (reset),
      .ctl         (btn1_ctl),
      .debounce_ms (debounce_ms_ff),
      .press       (press1)
   );

   dtrc_debounce u_btn2 (
      .clock       (clock),
      .reset       (reset),
      .ctl         (btn2_ctl),
      .debounce_ms (debounce_ms_ff),
      .press       (press2)
   );

   always_comb begin
      restore_val  = (req_chan.data.bright_last != '0) ? req_chan.data.bright_last
                                                      : fallback_ff;
      since_toggle = req_chan.data.now_ms - toggle_time_ff;
      sync_ok      = since_toggle >= {{(TimeWidth-CsrWidth){1'b0}}, guard_ms_ff};

      // button 1 toggles first; button 2 sees the brightness it restored
      ch1_mid    = ch1_ff ^ press1;
      restore1   = press1 && (ch1_mid || ch2_ff) && (req_chan.data.bright_now == '0);
      bright_mid = restore1 ? restore_val : req_chan.data.bright_now;
      restore2   = press2 && (ch1_mid || (ch2_ff ^ press2)) && (bright_mid == '0);

      ch1_in         = ch1_ff;
      ch2_in         = ch2_ff;
      toggle_time_in = toggle_time_ff;
      rsp_data_in    = '0;
      if (is_poll) begin
         ch1_in = ch1_mid;
         ch2_in = ch2_ff ^ press2;
         if (press1 || press2) begin
            toggle_time_in = req_chan.data.now_ms;
         end
         rsp_data_in.seg1_write   = press1;
         rsp_data_in.seg2_write   = press2;
         rsp_data_in.bright_write = restore1 || restore2;
         rsp_data_in.bright_value = (restore1 || restore2) ? restore_val : '0;
      end else if (sync_ok) begin
         ch1_in = req_chan.data.lit1;
         ch2_in = req_chan.data.lit2;
         rsp_data_in.sync_taken = 1'b1;
      end
      rsp_data_in.ch1_on    = ch1_in;
      rsp_data_in.ch2_on    = ch2_in;
      rsp_data_in.master_on = ch1_in || ch2_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch1_ff         <= 1'b0;
         ch2_ff         <= 1'b0;
         toggle_time_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            ch1_ff         <= ch1_in;
            ch2_ff         <= ch2_in;
            toggle_time_ff <= toggle_time_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // the response register mirrors the live channel state
   a_rsp_tracks_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.ch1_on == ch1_ff) && (rsp_data_ff.ch2_on == ch2_ff))
      else $error("response channel state differs from held state");

   a_master_or: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.master_on == (rsp_data_ff.ch1_on || rsp_data_ff.ch2_on))
      else $error("master relay is not the OR of the channels");

   a_sync_no_writes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.sync_taken) |->
         !(rsp_data_ff.seg1_write || rsp_data_ff.seg2_write || rsp_data_ff.bright_write))
      else $error("write request on a sync response");

   // a second toggle in the same poll may turn the last channel off again
   a_bright_needs_toggle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.bright_write) |->
         (rsp_data_ff.seg1_write || rsp_data_ff.seg2_write))
      else $error("brightness restore without a local toggle");

   a_toggle_stamps_time: assert property (@(posedge clock) disable iff (reset)
      (accept && is_poll && (press1 || press2)) |=> toggle_time_ff == $past(req_chan.data.now_ms))
      else $error("local toggle did not record its time");

endmodule
`default_nettype wire

// ===== tb/tb_debounced_toggle_relay_controller.sv =====
module tb_debounced_toggle_relay_controller;
   timeunit 1ns;
   timeprecision 1ps;

   import dtrc_pkg::*;

   // index past the last register: a write there must change nothing
   localparam logic [CsrIdxWidth-1:0] CSR_UNUSED = 2'd3;

   localparam int unsigned DirCount    = 22;
   localparam int unsigned PhaseItems  = 263;
   localparam rsp_type     NoRsp       = '0;

   typedef enum int unsigned {RX_STEADY, RX_CHOPPY, RX_SPARSE} rx_mode_type;

   typedef struct packed {
      logic    fixed;
      req_type item;
      rsp_type want;
   } dir_row_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [CsrWidth-1:0]    csr_wdata;

   dtrc_req_if req_if ();
   dtrc_rsp_if rsp_if ();

   debounced_toggle_relay_controller uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // relay and debounce state as the block should hold it
   logic [31:0] debounce_len;
   logic [31:0] guard_len;
   logic [7:0]  fallback_level;
   logic [1:0]  relay_on;
   logic [1:0]  btn_raw;
   logic [1:0]  btn_stable;
   logic [31:0] btn_since [2];
   logic [31:0] toggle_stamp;

   rsp_type     pending_rsp [$];
   int unsigned fault_count = 0;
   int unsigned burst_left;
   logic [31:0] stim_now;
   logic [1:0]  press_target;
   dir_row_type directed_rows [DirCount];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic press_detect(int unsigned b, logic level, logic [31:0] now);
      logic [31:0] held;
      if (level != btn_raw[b]) begin
         btn_raw[b]   = level;
         btn_since[b] = now;
      end
      held = now - btn_since[b];
      if (held > debounce_len && btn_stable[b] != btn_raw[b]) begin
         btn_stable[b] = btn_raw[b];
         return btn_stable[b] == LEVEL_PRESSED;
      end
      return 1'b0;
   endfunction

   function automatic rsp_type relay_response(req_type item);
      rsp_type     res;
      logic [1:0]  fired;
      logic [7:0]  bri;
      logic [31:0] since_toggle;
      res = '0;
      if (item.cmd == CMD_POLL) begin
         bri      = item.bright_now;
         fired[0] = press_detect(0, item.btn1_level, item.now_ms);
         fired[1] = press_detect(1, item.btn2_level, item.now_ms);
         for (int b = 0; b < 2; b++) begin
            if (fired[b]) begin
               relay_on[b] = ~relay_on[b];
               if (b == 0) res.seg1_write = 1'b1;
               else res.seg2_write = 1'b1;
               // second toggle sees the brightness already restored by the first
               if (relay_on != 2'b00 && bri == 8'd0) begin
                  bri = (item.bright_last != 8'd0) ? item.bright_last : fallback_level;
                  res.bright_write = 1'b1;
                  res.bright_value = bri;
               end
               toggle_stamp = item.now_ms;
            end
         end
      end else begin
         since_toggle = item.now_ms - toggle_stamp;
         if (since_toggle >= guard_len) begin
            relay_on       = {item.lit2, item.lit1};
            res.sync_taken = 1'b1;
         end
      end
      res.ch1_on    = relay_on[0];
      res.ch2_on    = relay_on[1];
      res.master_on = |relay_on;
      return res;
   endfunction

   function automatic req_type poll_req(logic [31:0] now, logic b1, logic b2,
                                        logic [7:0] bri, logic [7:0] last);
      req_type     item;
      logic [31:0] r;
      r                = $urandom;
      item.cmd         = CMD_POLL;
      item.now_ms      = now;
      item.btn1_level  = b1;
      item.btn2_level  = b2;
      item.bright_now  = bri;
      item.bright_last = last;
      item.lit1        = r[0];
      item.lit2        = r[1];
      return item;
   endfunction

   function automatic req_type sync_req(logic [31:0] now, logic l1, logic l2);
      req_type     item;
      logic [31:0] r;
      r                = $urandom;
      item.cmd         = CMD_SYNC;
      item.now_ms      = now;
      item.btn1_level  = r[0];
      item.btn2_level  = r[1];
      item.bright_now  = r[15:8];
      item.bright_last = r[23:16];
      item.lit1        = l1;
      item.lit2        = l2;
      return item;
   endfunction

   // mostly press/release sequences held around the debounce time, some syncs around the guard time, bounce and noise
   function automatic req_type next_traffic();
      req_type     item;
      logic [31:0] r;
      logic [31:0] s;
      logic [31:0] offset;
      logic [31:0] step;
      logic        lv1;
      logic        lv2;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      r    = $urandom;
      s    = $urandom;
      if (pick < 7) begin
         item.cmd         = r[0];
         item.now_ms      = s;
         item.btn1_level  = r[1];
         item.btn2_level  = r[2];
         item.lit1        = r[3];
         item.lit2        = r[4];
         item.bright_now  = r[15:8];
         item.bright_last = r[23:16];
      end else if (pick < 27) begin
         case (r[1:0])
            2'd0: offset = guard_len - 32'd1;
            2'd1: offset = guard_len;
            2'd2: offset = guard_len + 32'd1;
            default: offset = $urandom_range(0, 2 * guard_len + 2);
         endcase
         item = sync_req(toggle_stamp + offset, r[2], r[3]);
      end else begin
         if (r[3:0] < 4'd5) press_target[0] = ~press_target[0];
         if (r[7:4] < 4'd5) press_target[1] = ~press_target[1];
         case (r[9:8])
            2'd0: step = $urandom_range(0, debounce_len / 2);
            2'd1: step = debounce_len + {31'd0, r[10]};
            default: step = $urandom_range(debounce_len + 1, 2 * debounce_len + 2);
         endcase
         stim_now = stim_now + step;
         // brief bounce against the held level
         lv1 = press_target[0] ^ (r[15:12] == 4'd0);
         lv2 = press_target[1] ^ (r[19:16] == 4'd0);
         item = poll_req(stim_now, lv1, lv2, r[20] ? 8'd0 : r[31:24],
                         (s[1:0] == 2'd0) ? 8'd0 : s[15:8]);
      end
      return item;
   endfunction

   // enter and leave at a falling edge
   task automatic send_item(input req_type item, input logic fixed, input rsp_type want);
      rsp_type predicted;
      if (burst_left == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= item;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predicted = relay_response(item);
      pending_rsp.push_back(fixed ? want : predicted);
      burst_left--;
      @(negedge clock);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CsrIdxWidth-1:0] idx, input logic [CsrWidth-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_DEBOUNCE_MS:     debounce_len   = {16'd0, data};
         CSR_GUARD_MS:        guard_len      = {16'd0, data};
         CSR_FALLBACK_BRIGHT: fallback_level = data[7:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic configure(input logic [CsrWidth-1:0] db, input logic [CsrWidth-1:0] gd,
                            input logic [CsrWidth-1:0] fb, input logic poke_unused);
      csr_write(CSR_DEBOUNCE_MS, db);
      if (poke_unused) csr_write(CSR_UNUSED, 16'($urandom));
      csr_write(CSR_GUARD_MS, gd);
      csr_write(CSR_FALLBACK_BRIGHT, fb);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_traffic(input int unsigned count);
      logic [31:0] r;
      r = $urandom;
      case (r[1:0])
         2'd0: stim_now = $urandom;
         2'd1: stim_now = 32'd0 - (debounce_len << 3) - 32'd7;
         default: ;
      endcase
      repeat (count) send_item(next_traffic(), 1'b0, NoRsp);
      drain();
   endtask

   initial begin : main
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.data  = '0;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;

      debounce_len   = 32'(DEBOUNCE_MS_RESET);
      guard_len      = 32'(GUARD_MS_RESET);
      fallback_level = FALLBACK_BRIGHT_RESET;
      relay_on       = 2'b00;
      btn_raw        = {2{LEVEL_RELEASED}};
      btn_stable     = {2{LEVEL_RELEASED}};
      btn_since[0]   = '0;
      btn_since[1]   = '0;
      toggle_stamp   = '0;
      press_target   = {2{LEVEL_RELEASED}};
      stim_now       = '0;
      burst_left     = 0;

      // early syncs are dropped since the toggle stamp starts at zero
      directed_rows[0]  = '{1'b1, sync_req(32'd0, 1'b1, 1'b1), NoRsp};
      directed_rows[1]  = '{1'b1, sync_req(32'd499, 1'b1, 1'b1), NoRsp};
      directed_rows[2]  = '{1'b1, sync_req(32'd500, 1'b1, 1'b1),
                            rsp_type'{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 1'b1}};
      directed_rows[3]  = '{1'b1, sync_req(32'd600, 1'b0, 1'b0),
                            rsp_type'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b1}};
      // both pressed: stable only once strictly more than the debounce time passes
      directed_rows[4]  = '{1'b1, poll_req(32'd1000, 1'b0, 1'b0, 8'd0, 8'd0), NoRsp};
      directed_rows[5]  = '{1'b1, poll_req(32'd1050, 1'b0, 1'b0, 8'd0, 8'd0), NoRsp};
      directed_rows[6]  = '{1'b1, poll_req(32'd1051, 1'b0, 1'b0, 8'd0, 8'd0),
                            rsp_type'{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'd128, 1'b0}};
      directed_rows[7]  = '{1'b1, sync_req(32'd1550, 1'b0, 1'b0),
                            rsp_type'{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0}};
      directed_rows[8]  = '{1'b0, poll_req(32'd1600, 1'b1, 1'b1, 8'd0, 8'd0), NoRsp};
      directed_rows[9]  = '{1'b0, poll_req(32'd1700, 1'b1, 1'b1, 8'd0, 8'd0), NoRsp};
      directed_rows[10] = '{1'b0, poll_req(32'd1800, 1'b0, 1'b1, 8'd0, 8'd200), NoRsp};
      directed_rows[11] = '{1'b0, poll_req(32'd1900, 1'b0, 1'b1, 8'd0, 8'd200), NoRsp};
      directed_rows[12] = '{1'b0, poll_req(32'd1950, 1'b0, 1'b0, 8'd255, 8'd255), NoRsp};
      directed_rows[13] = '{1'b0, poll_req(32'd2100, 1'b0, 1'b0, 8'd255, 8'd255), NoRsp};
      directed_rows[14] = '{1'b0, sync_req(32'hFFFF_FFFF, 1'b1, 1'b0), NoRsp};
      // debounce across the timestamp wrap
      directed_rows[15] = '{1'b0, poll_req(32'hFFFF_FFF0, 1'b1, 1'b1, 8'h55, 8'd0), NoRsp};
      directed_rows[16] = '{1'b0, poll_req(32'h0000_0030, 1'b1, 1'b1, 8'h55, 8'd0), NoRsp};
      directed_rows[17] = '{1'b0, poll_req(32'h0000_0040, 1'b0, 1'b1, 8'd0, 8'd1), NoRsp};
      directed_rows[18] = '{1'b0, poll_req(32'h0000_0080, 1'b0, 1'b1, 8'd0, 8'd1), NoRsp};
      directed_rows[19] = '{1'b0, sync_req(32'h0000_0080 + 32'd499, 1'b0, 1'b1), NoRsp};
      directed_rows[20] = '{1'b0, sync_req(32'h0000_0080 + 32'd500, 1'b0, 1'b1), NoRsp};
      directed_rows[21] = '{1'b0, poll_req(32'hFFFF_FFFF, 1'b1, 1'b0, 8'd0, 8'hFF), NoRsp};

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int n = 0; n < DirCount; n++)
         send_item(directed_rows[n].item, directed_rows[n].fixed, directed_rows[n].want);
      drain();

      run_traffic(PhaseItems);
      configure(16'd0, 16'd0, 16'd1, 1'b1);
      run_traffic(PhaseItems);
      configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      run_traffic(PhaseItems);
      // fallback of zero: restore requests a write of zero
      configure(16'd3, 16'd10, 16'hA500, 1'b1);
      run_traffic(PhaseItems);
      repeat (2) begin
         configure(16'($urandom_range(1, 300)), 16'($urandom_range(0, 2000)),
                   {8'($urandom), 8'($urandom_range(1, 255))}, 1'b0);
         run_traffic(PhaseItems);
      end

      drain();
      repeat (5) @(negedge clock);
      if (fault_count == 0) begin
         $display("tb_debounced_toggle_relay_controller: clean");
      end else begin
         $display("tb_debounced_toggle_relay_controller: errors");
      end
      $finish;
   end

   // result side: own stall pattern plus a periodic long hold-off that backs up the input
   initial begin : rsp_stall
      int unsigned cyc;
      int unsigned hold_left;
      int unsigned mode_left;
      rx_mode_type mode;
      cyc          = 0;
      hold_left    = 0;
      mode_left    = 0;
      mode         = RX_STEADY;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc % 900 == 300) hold_left = $urandom_range(40, 80);
         if (mode_left == 0) begin
            mode      = rx_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            case (mode)
               RX_STEADY: rsp_if.ready <= 1'b1;
               RX_CHOPPY: rsp_if.ready <= ($urandom_range(0, 1) == 0);
               default:   rsp_if.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      rsp_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.data;
         if (pending_rsp.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("%0t: unexpected result item %h", $realtime, got);
         end else begin
            want = pending_rsp.pop_front();
            if (got.ch1_on !== want.ch1_on || got.ch2_on !== want.ch2_on ||
                got.master_on !== want.master_on || got.seg1_write !== want.seg1_write ||
                got.seg2_write !== want.seg2_write ||
                got.bright_write !== want.bright_write ||
                got.bright_value !== want.bright_value ||
                got.sync_taken !== want.sync_taken) begin
               fault_count++;
               if (fault_count <= 10)
                  $display({"%0t: mismatch ch=%b%b master=%b seg=%b%b bw=%b bv=%0d",
                            " taken=%b, got ch=%b%b master=%b seg=%b%b bw=%b bv=%0d taken=%b"},
                           $realtime, want.ch1_on, want.ch2_on, want.master_on,
                           want.seg1_write, want.seg2_write, want.bright_write,
                           want.bright_value, want.sync_taken, got.ch1_on, got.ch2_on,
                           got.master_on, got.seg1_write, got.seg2_write, got.bright_write,
                           got.bright_value, got.sync_taken);
            end
         end
      end
   end

   initial begin : watchdog
      #10_000_000;
      $display("tb_debounced_toggle_relay_controller: errors");
      $finish;
   end

endmodule
